/* hw/rtl/rds_rta_pkg.sv */
// Shared types and constants for the RDS PS / radiotext assembler.
// Holds the channel payload structs and the decoded group operation struct.
// No dependencies.
package rds_rta_pkg;

    localparam logic [4:0]  GROUP_0A_CODE  = 5'h00;
    localparam logic [4:0]  GROUP_2A_CODE  = 5'h04;
    localparam int          TEXT_FLAG_POS  = 4;
    localparam logic [7:0]  CHAR_CR        = 8'h0D;
    localparam logic [3:0]  PS_ALL         = 4'hF;
    localparam logic [15:0] RT_ALL         = 16'hFFFF;
    localparam int          RT_ROWS        = 16;
    localparam int          RT_ROW_W       = $clog2(RT_ROWS);
    localparam int          PS_SEGS        = 4;
    localparam int          PS_SEG_W       = $clog2(PS_SEGS);

    typedef enum logic
    {
        KIND_GROUP = 1'b0,
        KIND_READ  = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t                kind;
        logic [15:0]          block_a;
        logic [15:0]          block_b;
        logic [15:0]          block_c;
        logic [15:0]          block_d;
        logic [RT_ROW_W-1:0]  text_index;
    } in_item_t;

    typedef struct packed
    {
        logic [15:0] prog_ident;
        logic        complete;
        logic [63:0] ps_text;
        logic [3:0]  ps_seen;
        logic [15:0] rt_seen;
        logic [31:0] text_word;
    } out_item_t;

    // State update that one group causes.
    typedef struct packed
    {
        logic                 pi_we;
        logic [15:0]          pi;
        logic                 ps_we;
        logic [PS_SEG_W-1:0]  ps_seg;
        logic [15:0]          ps_chars;
        logic                 rt_we;
        logic [RT_ROW_W-1:0]  rt_seg;
        logic [31:0]          rt_word;
        logic                 rt_cr;
    } grp_op_t;

endpackage

/* hw/rtl/rds_rta_stream.sv */
// Valid/ready stream interface used for both channels of the assembler.
// The payload type is chosen per instance from the types in rds_rta_pkg.
interface rds_rta_stream #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* hw/rtl/rds_ps_radiotext_assembler_unit.sv */
// Channel   Direction  Payload     Content
// in_ch     sink       in_item_t   one RDS group (kind 0) or a radiotext read (kind 1)
// out_ch    source     out_item_t  identifier, PS text, masks, completion, text word
//
// Every beat waits in the input register and then moves to the result slot; a new
// beat can be taken every cycle while out_ch is not stalled. The state update and
// the radiotext read happen at the edge that moves an item into the result slot.
// Reset clears the state stores at once; the radiotext memory rows carry valid bits instead.
// A stall on out_ch holds the result and backs up into in_ch after one more beat.
// Depends on rds_rta_pkg, rds_rta_stream and the three submodules below.
module rds_ps_radiotext_assembler_unit
(
    input  logic                clk,
    input  logic                rst_n,
    rds_rta_stream.sink         in_ch,
    rds_rta_stream.source       out_ch
);
    import rds_rta_pkg::*;

    // Input register: the item waiting for the result slot.
    in_item_t item_reg;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    // Result slot. Its fields live in the state registers and the read register
    // of the text memory, which only change when a new item moves in.
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     commit;
    grp_op_t  op;
    out_item_t result;

    // An item moves on when the result slot is empty or is being emptied now.
    assign commit      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || commit;

    always_comb
    begin
        s1_valid_next  = in_ch.ready ? in_ch.valid : s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= in_ch.payload;
        end
    end

    rds_rta_decode u_decode
    (
        .item (item_reg),
        .op   (op)
    );

    rds_rta_state u_state
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (commit),
        .op         (op),
        .prog_ident (result.prog_ident),
        .ps_text    (result.ps_text),
        .ps_seen    (result.ps_seen),
        .rt_seen    (result.rt_seen)
    );

    rds_rta_text_mem u_text_mem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .op        (op),
        .rd_en     (item_reg.kind == KIND_READ),
        .rd_row    (item_reg.text_index),
        .text_word (result.text_word)
    );

    // Completion is a plain function of the two masks in the result slot.
    assign result.complete = (result.ps_seen == PS_ALL) && (result.rt_seen == RT_ALL);

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = result;

endmodule

/* hw/rtl/rds_rta_decode.sv */
// Group decoder: turns one RDS group into the state update it causes.
// Depends on rds_rta_pkg.
module rds_rta_decode
(
    input  rds_rta_pkg::in_item_t item,
    output rds_rta_pkg::grp_op_t  op
);
    import rds_rta_pkg::*;

    logic [4:0] group_type;
    logic [7:0] rt_char [4];
    logic [3:0] char_is_cr;

    assign group_type = item.block_b[15:11];
    assign rt_char[0] = item.block_c[15:8];
    assign rt_char[1] = item.block_c[7:0];
    assign rt_char[2] = item.block_d[15:8];
    assign rt_char[3] = item.block_d[7:0];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            char_is_cr[i] = (rt_char[i] == CHAR_CR);
        end
    end

    always_comb
    begin
        op          = '0;
        op.pi       = item.block_a;
        op.ps_seg   = item.block_b[PS_SEG_W-1:0];
        op.ps_chars = item.block_d;
        op.rt_seg   = item.block_b[RT_ROW_W-1:0];
        // A carriage return is stored as a zero character.
        op.rt_word  = {char_is_cr[0] ? 8'h00 : rt_char[0],
                       char_is_cr[1] ? 8'h00 : rt_char[1],
                       char_is_cr[2] ? 8'h00 : rt_char[2],
                       char_is_cr[3] ? 8'h00 : rt_char[3]};
        op.rt_cr    = |char_is_cr;
        if (item.kind == KIND_GROUP)
        begin
            op.pi_we = 1'b1;
            if (group_type == GROUP_0A_CODE)
            begin
                op.ps_we = 1'b1;
            end
            else if (group_type == GROUP_2A_CODE && !item.block_b[TEXT_FLAG_POS])
            begin
                op.rt_we = 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/rds_rta_state.sv */
// Program identifier, PS character store and the two segment masks.
// Depends on rds_rta_pkg.
module rds_rta_state
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 commit,
    input  rds_rta_pkg::grp_op_t op,
    output logic [15:0]          prog_ident,
    output logic [63:0]          ps_text,
    output logic [3:0]           ps_seen,
    output logic [15:0]          rt_seen
);
    import rds_rta_pkg::*;

    logic [15:0] pi_reg;
    logic [15:0] pi_next;
    logic [15:0] ps_word_reg  [PS_SEGS];
    logic [15:0] ps_word_next [PS_SEGS];
    logic [3:0]  ps_mask_reg;
    logic [3:0]  ps_mask_next;
    logic [15:0] rt_mask_reg;
    logic [15:0] rt_mask_next;

    always_comb
    begin
        pi_next      = pi_reg;
        ps_word_next = ps_word_reg;
        ps_mask_next = ps_mask_reg;
        rt_mask_next = rt_mask_reg;
        if (commit)
        begin
            if (op.pi_we)
            begin
                pi_next = op.pi;
            end
            if (op.ps_we)
            begin
                ps_word_next[op.ps_seg] = op.ps_chars;
                ps_mask_next = ps_mask_reg | (4'b0001 << op.ps_seg);
            end
            if (op.rt_we)
            begin
                // A carriage return finishes the whole text at once.
                rt_mask_next = op.rt_cr ? RT_ALL : (rt_mask_reg | (16'h0001 << op.rt_seg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pi_reg      <= '0;
            ps_word_reg <= '{default: '0};
            ps_mask_reg <= '0;
            rt_mask_reg <= '0;
        end
        else
        begin
            pi_reg      <= pi_next;
            ps_word_reg <= ps_word_next;
            ps_mask_reg <= ps_mask_next;
            rt_mask_reg <= rt_mask_next;
        end
    end

    assign prog_ident = pi_reg;
    assign ps_text    = {ps_word_reg[0], ps_word_reg[1], ps_word_reg[2], ps_word_reg[3]};
    assign ps_seen    = ps_mask_reg;
    assign rt_seen    = rt_mask_reg;

endmodule

/* hw/rtl/rds_rta_text_mem.sv */
// Radiotext store: 16 rows of four characters with a valid bit per row.
// Depends on rds_rta_pkg. Rows never written read as zero.
module rds_rta_text_mem
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           commit,
    input  rds_rta_pkg::grp_op_t           op,
    input  logic                           rd_en,
    input  logic [rds_rta_pkg::RT_ROW_W-1:0] rd_row,
    output logic [31:0]                    text_word
);
    import rds_rta_pkg::*;

    logic [31:0]        mem [RT_ROWS];
    logic [RT_ROWS-1:0] row_valid_reg;
    logic [RT_ROWS-1:0] row_valid_next;
    logic [31:0]        rd_data_reg;
    logic               rd_hit_reg;
    logic               rd_hit_next;

    always_ff @(posedge clk)
    begin
        if (commit && op.rt_we)
        begin
            mem[op.rt_seg] <= op.rt_word;
        end
        if (commit)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    always_comb
    begin
        row_valid_next = row_valid_reg;
        rd_hit_next    = rd_hit_reg;
        if (commit)
        begin
            rd_hit_next = rd_en && row_valid_reg[rd_row];
            if (op.rt_we)
            begin
                row_valid_next[op.rt_seg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rd_hit_reg    <= rd_hit_next;
        end
    end

    assign text_word = rd_hit_reg ? rd_data_reg : 32'h0;

endmodule

/* hw/rtl/rds_rta_checker.sv */
// Port-level checks for the RDS PS / radiotext assembler, bound to the top level.
// Depends on rds_rta_pkg.
module rds_rta_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        complete,
    input logic [3:0]  ps_seen,
    input logic [15:0] rt_seen
);
    import rds_rta_pkg::*;

    a_complete_matches_masks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (complete == ((ps_seen == PS_ALL) && (rt_seen == RT_ALL))))
        else $error("complete does not match the segment masks");

    a_ps_seen_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && $past(out_valid)) |-> ((ps_seen & $past(ps_seen)) == $past(ps_seen)))
        else $error("a PS segment bit was cleared");

    a_rt_seen_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && $past(out_valid)) |-> ((rt_seen & $past(rt_seen)) == $past(rt_seen)))
        else $error("a radiotext segment bit was cleared");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped while stalled");

endmodule

bind rds_ps_radiotext_assembler_unit rds_rta_port_checker u_rds_rta_port_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .complete  (out_ch.payload.complete),
    .ps_seen   (out_ch.payload.ps_seen),
    .rt_seen   (out_ch.payload.rt_seen)
);

/* sim/rds_rta_checker.sv */
// Scoreboard for the RDS PS / radiotext assembler: watches both channels,
// keeps its own copy of the identifier, PS and radiotext stores and compares results.
// Depends on rds_rta_pkg.
module rds_rta_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  rds_rta_pkg::in_item_t in_item,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  rds_rta_pkg::out_item_t out_item,
    output int                    pending,
    output int                    mismatches
);

    timeunit 1ns;
    timeprecision 1ps;

    import rds_rta_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [15:0] pi_model;
    logic [7:0]  ps_chars [8];
    logic [7:0]  rt_chars [64];
    logic [3:0]  ps_mask_model;
    logic [15:0] rt_mask_model;
    out_item_t   results_due [$];

    // Applies one beat to the local stores and returns the result it must produce.
    task automatic assemble(input in_item_t it, output out_item_t res);
        logic [4:0]  gtype;
        logic [31:0] chars;
        logic [7:0]  ch;
        int          base;
        res = '0;
        if (it.kind == KIND_GROUP)
        begin
            pi_model = it.block_a;
            gtype    = it.block_b[15:11];
            if (gtype == GROUP_0A_CODE)
            begin
                base = 2 * int'(it.block_b[1:0]);
                ps_chars[base]     = it.block_d[15:8];
                ps_chars[base + 1] = it.block_d[7:0];
                ps_mask_model[it.block_b[1:0]] = 1'b1;
            end
            else if (gtype == GROUP_2A_CODE && !it.block_b[TEXT_FLAG_POS])
            begin
                base  = 4 * int'(it.block_b[3:0]);
                chars = {it.block_c, it.block_d};
                for (int i = 0; i < 4; i++)
                begin
                    ch = chars[31 - 8 * i -: 8];
                    // A carriage return is kept as a zero and closes the whole text.
                    if (ch == CHAR_CR)
                    begin
                        ch = 8'h00;
                        rt_mask_model = RT_ALL;
                    end
                    rt_chars[base + i] = ch;
                end
                rt_mask_model[it.block_b[3:0]] = 1'b1;
            end
        end
        else
        begin
            base = 4 * int'(it.text_index);
            for (int i = 0; i < 4; i++)
                res.text_word = {res.text_word[23:0], rt_chars[base + i]};
        end
        for (int i = 0; i < 8; i++)
            res.ps_text = {res.ps_text[55:0], ps_chars[i]};
        res.prog_ident = pi_model;
        res.ps_seen    = ps_mask_model;
        res.rt_seen    = rt_mask_model;
        res.complete   = (ps_mask_model == PS_ALL) && (rt_mask_model == RT_ALL);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t fresh;
        if (!rst_n)
        begin
            pi_model      = '0;
            ps_mask_model = '0;
            rt_mask_model = '0;
            for (int i = 0; i < 8; i++)
                ps_chars[i] = '0;
            for (int i = 0; i < 64; i++)
                rt_chars[i] = '0;
            results_due.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat with nothing outstanding: %h",
                                 $realtime, out_item);
                end
                else
                begin
                    want = results_due.pop_front();
                    compare_field("prog_ident", 64'(want.prog_ident), 64'(out_item.prog_ident));
                    compare_field("complete",   64'(want.complete),   64'(out_item.complete));
                    compare_field("ps_text",    want.ps_text,         out_item.ps_text);
                    compare_field("ps_seen",    64'(want.ps_seen),    64'(out_item.ps_seen));
                    compare_field("rt_seen",    64'(want.rt_seen),    64'(out_item.rt_seen));
                    compare_field("text_word",  64'(want.text_word),  64'(out_item.text_word));
                end
            end
            if (in_valid && in_ready)
            begin
                assemble(in_item, fresh);
                results_due.push_back(fresh);
            end
            pending = results_due.size();
        end
    end

endmodule

/* sim/rds_ps_radiotext_assembler_unit_tb.sv */
// Top of the assembler testbench: clock, reset, group and read stimulus, back pressure.
// Checking lives in rds_rta_checker; depends on rds_rta_pkg and rds_rta_stream.
module rds_ps_radiotext_assembler_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rds_rta_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_LEN    = 250;
    localparam int HOLD_CYCLES  = 200;
    // In a correct run beats stop moving only for a receiver hold-off plus a few drawn gaps.
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 4;

    logic clk;
    logic rst_n;

    rds_rta_stream #(.payload_t(in_item_t))  in_ch ();
    rds_rta_stream #(.payload_t(out_item_t)) out_ch ();

    int pending;
    int mismatches;

    // Largest gap each side may draw per beat; zero gives stretches with no idling.
    int in_gap_max;
    int out_gap_max;

    // The stimulus asks for a long receiver hold-off by bumping hold_asked; the
    // receiver process serves it and bumps hold_given.
    int hold_asked;
    int hold_given;

    rds_ps_radiotext_assembler_unit i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    rds_rta_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_item    (in_ch.payload),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_item   (out_ch.payload),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: ends the run when no beat has moved on either channel for too long.
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Result side: draws a wait before each beat it takes, or serves a long hold-off.
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        hold_given   = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_asked != hold_given)
            begin
                hold_given++;
                gap = HOLD_CYCLES;
            end
            else
                gap = $urandom_range(out_gap_max, 0);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Offers one beat after a drawn gap and returns at the falling edge after it was
    // taken. Valid stays high across back-to-back beats, so it is never dropped and
    // raised again within one step.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = $urandom_range(in_gap_max, 0);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic in_item_t group_beat(logic [15:0] a, logic [15:0] b,
                                            logic [15:0] c, logic [15:0] d);
        in_item_t it;
        it.kind       = KIND_GROUP;
        it.block_a    = a;
        it.block_b    = b;
        it.block_c    = c;
        it.block_d    = d;
        it.text_index = 4'($urandom_range(15, 0));
        return it;
    endfunction

    // Blocks of a read beat carry random junk, which the block must ignore.
    function automatic in_item_t read_beat(logic [3:0] idx);
        in_item_t it;
        it            = group_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        it.kind       = KIND_READ;
        it.text_index = idx;
        return it;
    endfunction

    // Text characters, with an occasional carriage return.
    function automatic logic [7:0] text_char();
        if ($urandom_range(19, 0) == 0)
            return CHAR_CR;
        return 8'($urandom_range(255, 0));
    endfunction

    // Mostly well-formed PS and radiotext groups, plus reads and noise groups
    // whose block B is fully random (other types, text flag B, stray bits).
    function automatic in_item_t random_beat();
        int          pick;
        logic [15:0] b;
        pick = $urandom_range(99, 0);
        if (pick < 30)
        begin
            b = {GROUP_0A_CODE, 11'($urandom)};
            return group_beat(16'($urandom), b, 16'($urandom),
                              {text_char(), text_char()});
        end
        if (pick < 65)
        begin
            b = {GROUP_2A_CODE, 11'($urandom)};
            b[TEXT_FLAG_POS] = 1'b0;
            return group_beat(16'($urandom), b, {text_char(), text_char()},
                              {text_char(), text_char()});
        end
        if (pick < 85)
            return read_beat(4'($urandom_range(15, 0)));
        return group_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    initial
    begin
        in_item_t directed [$];
        int       phase;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        in_gap_max    = 5;
        out_gap_max   = 5;
        hold_asked    = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. Reads of the cleared store come first, then PS segments and
        // radiotext segments without a carriage return so the masks grow bit by bit,
        // then group types that only touch the identifier, and the carriage return cases
        // after the radiotext segments that grow the mask, since they pin it at all ones for good.
        directed.push_back(read_beat(4'd0));
        directed.push_back(read_beat(4'd15));
        directed.push_back(group_beat(16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
        directed.push_back(group_beat(16'hFFFF, 16'h07FD, 16'hFFFF, 16'h0000));
        directed.push_back(group_beat(16'h1234, 16'h2000, 16'h4142, 16'h4344));
        directed.push_back(group_beat(16'hABCD, 16'h27EF, 16'hFFFF, 16'hFFFF));
        // Text flag B: identifier only.
        directed.push_back(group_beat(16'h5555, 16'h27FF, 16'h1111, 16'h2222));
        // Unhandled group types: identifier only.
        directed.push_back(group_beat(16'hAAAA, 16'hF800, 16'h3333, 16'h4444));
        directed.push_back(group_beat(16'h0001, 16'h0802, 16'h5555, 16'h6666));
        directed.push_back(read_beat(4'd0));
        directed.push_back(read_beat(4'd15));
        directed.push_back(read_beat(4'd7));
        directed.push_back(group_beat(16'h8001, 16'hF7FE & 16'h07FE, 16'h0000, 16'h5053));
        directed.push_back(group_beat(16'h7FFE, 16'h0003, 16'h0000, 16'h2020));
        // Carriage return in the first character, then in the last three.
        directed.push_back(group_beat(16'h0F0F, 16'h2005, 16'h0D41, 16'h4243));
        directed.push_back(read_beat(4'd5));
        directed.push_back(group_beat(16'hF0F0, 16'h2006, 16'h410D, 16'h0D0D));
        directed.push_back(read_beat(4'd6));
        // In PS text a carriage return is an ordinary character.
        directed.push_back(group_beat(16'hC3C3, 16'h0000, 16'h0000, 16'h0D0D));
        directed.push_back(group_beat(16'h3C3C, 16'h2003, 16'h0000, 16'h0000));
        directed.push_back(read_beat(4'd3));
        directed.push_back(read_beat(4'd15));
        foreach (directed[i])
            send_item(directed[i]);

        // Random part in phases that vary the idling on both sides.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                phase = n / PHASE_LEN;
                in_gap_max  = (phase % 4 == 0 || phase % 4 == 2) ? 0 : 5;
                out_gap_max = (phase % 4 == 0 || phase % 4 == 3) ? 0 : 5;
            end
            // Receiver holds off while beats keep being offered, so the block backs up.
            if (n == RANDOM_ITEMS / 4 || n == 3 * RANDOM_ITEMS / 4)
                hold_asked++;
            // Sender goes quiet until every outstanding result has drained.
            if (n == RANDOM_ITEMS / 2)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
            end
            send_item(random_beat());
        end
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
